// ----- design/fsq_pkg.sv -----
// ----------------------------------------------------------------------------
// fsq_pkg
// Shared types and constants for the four-sum quadruple search block.
// ----------------------------------------------------------------------------
package fsq_pkg;

   localparam int MAX_ELEMENTS_DEFAULT = 64;
   localparam int DATA_WIDTH           = 32;

   typedef logic [1:0] opcode_type;

   localparam opcode_type OP_CLEAR = 2'd0;
   localparam opcode_type OP_LOAD  = 2'd1;

   typedef enum logic [2:0] {
      ST_CLEARED   = 3'd0,
      ST_STORED    = 3'd1,
      ST_FOUND     = 3'd2,
      ST_EXHAUSTED = 3'd3,
      ST_FULL      = 3'd4
   } status_type;

endpackage

// ----- design/fsq_if.sv -----
// ----------------------------------------------------------------------------
// fsq_if
// Valid/ready channels: request transactions in, response transactions out.
// ----------------------------------------------------------------------------
interface fsq_req_if;
   logic              valid;
   logic              ready;
   logic [1:0]        opcode;
   logic signed [31:0] value;

   modport source (output valid, output opcode, output value, input ready);
   modport sink   (input valid, input opcode, input value, output ready);
endinterface

interface fsq_rsp_if;
   logic               valid;
   logic               ready;
   logic [2:0]         status;
   logic signed [31:0] first_value;
   logic signed [31:0] second_value;
   logic signed [31:0] third_value;
   logic signed [31:0] fourth_value;

   modport source (output valid, output status, output first_value,
                   output second_value, output third_value, output fourth_value,
                   input ready);
   modport sink   (input valid, input status, input first_value,
                   input second_value, input third_value, input fourth_value,
                   output ready);
endinterface

// ----- design/fsq_ram.sv -----
// ----------------------------------------------------------------------------
// fsq_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module fsq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write and read, read data registered
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/four_sum_quadruple_search_core.sv -----
// ----------------------------------------------------------------------------
// four_sum_quadruple_search_core
// Sorted store with insertion on load and a two-pointer quadruple search
// driven one fetch at a time.
// ----------------------------------------------------------------------------
//  channel   dir  handshake        payload
//  req_chan  in   valid/ready      opcode, value
//  rsp_chan  out  valid/ready      status, first..fourth_value
//  csr_*     in   write enable     target_sum (32-bit signed)
//
//  One transaction at a time through a single-read-port store.
//  Clear goes straight to the response. Load: each larger element is read and
//  written one place up, then the value goes into the gap, with no read when it
//  reaches the bottom of the store. Fetch: opens a new search if none is active,
//  then steps the two pointers, reading low then high, and advances the second
//  and outer indices past duplicates until a hit or the search is exhausted.
//  Synchronous active-high reset empties the store logically; no clearing pass.
//  A stalled response holds the block in its response state.
// ----------------------------------------------------------------------------
module four_sum_quadruple_search_core #(
   parameter int MAX_ELEMENTS = fsq_pkg::MAX_ELEMENTS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   fsq_req_if.sink                        req_chan,
   fsq_rsp_if.source                      rsp_chan,
   input  logic                           csr_write_enable,
   input  logic [fsq_pkg::DATA_WIDTH-1:0] csr_write_data
);
   import fsq_pkg::*;

   localparam int AW = $clog2(MAX_ELEMENTS);
   localparam int CW = $clog2(MAX_ELEMENTS + 1);
   localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_ELEMENTS);
   localparam logic [CW-1:0] ONE       = CW'(1);

   typedef enum logic [3:0] {
      S_IDLE, S_INS, S_INS_D, S_START_D, S_AP_NEXT, S_AP_D, S_OI_NEXT, S_OI_D,
      S_W_CHK, S_W_C, S_W_D, S_SK_L, S_SK_LD, S_SK_H, S_SK_HD, S_RESP
   } state_type;

   state_type state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in, oi_ff, oi_in, si_ff, si_in;
   logic [CW-1:0] lo_ff, lo_in, hi_ff, hi_in, pos_ff, pos_in;
   logic active_ff, active_in, finished_ff, finished_in;
   logic signed [31:0] a_ff, a_in, b_ff, b_in, c_ff, c_in, d_ff, d_in;
   logic signed [31:0] val_ff, val_in, target_sum_ff, target_sum_in;
   logic signed [32:0] ab_ff, ab_in;
   status_type pend_ff, pend_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [2:0] rsp_status_ff, rsp_status_in;
   logic signed [31:0] rsp_q0_ff, rsp_q0_in, rsp_q1_ff, rsp_q1_in;
   logic signed [31:0] rsp_q2_ff, rsp_q2_in, rsp_q3_ff, rsp_q3_in;

   logic          ram_we, ram_re;
   logic [AW-1:0] ram_wa, ram_ra;
   logic [31:0]   ram_wd, ram_rd;
   logic signed [31:0] rdata;
   logic signed [33:0] quad_sum, target_ext;
   logic [CW-1:0] nxt_si, nxt_oi;

   fsq_ram #(.WIDTH(DATA_WIDTH), .DEPTH(MAX_ELEMENTS)) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_en   (ram_re),
      .rd_addr (ram_ra),
      .rd_data (ram_rd)
   );

   assign rdata      = $signed(ram_rd);
   assign nxt_si     = si_ff + ONE;
   assign nxt_oi     = oi_ff + ONE;
   assign quad_sum   = 34'(ab_ff) + 34'(c_ff) + 34'(rdata);
   assign target_ext = 34'(target_sum_ff);

   assign req_chan.ready        = (state_ff == S_IDLE);
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status       = rsp_status_ff;
   assign rsp_chan.first_value  = rsp_q0_ff;
   assign rsp_chan.second_value = rsp_q1_ff;
   assign rsp_chan.third_value  = rsp_q2_ff;
   assign rsp_chan.fourth_value = rsp_q3_ff;

   // sequencer: next state, store accesses and search bookkeeping
   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      oi_in         = oi_ff;
      si_in         = si_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      pos_in        = pos_ff;
      active_in     = active_ff;
      finished_in   = finished_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      c_in          = c_ff;
      d_in          = d_ff;
      ab_in         = ab_ff;
      val_in        = val_ff;
      pend_in       = pend_ff;
      target_sum_in = csr_write_enable ? $signed(csr_write_data) : target_sum_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_q0_in     = rsp_q0_ff;
      rsp_q1_in     = rsp_q1_ff;
      rsp_q2_in     = rsp_q2_ff;
      rsp_q3_in     = rsp_q3_ff;
      ram_we        = 1'b0;
      ram_wa        = '0;
      ram_wd        = '0;
      ram_re        = 1'b0;
      ram_ra        = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               case (req_chan.opcode)
                  OP_CLEAR: begin
                     cnt_in      = '0;
                     active_in   = 1'b0;
                     finished_in = 1'b0;
                     oi_in = '0; si_in = '0; lo_in = '0; hi_in = '0;
                     pend_in     = ST_CLEARED;
                     state_in    = S_RESP;
                  end
                  OP_LOAD: begin
                     if (cnt_ff >= MAX_COUNT) begin
                        pend_in  = ST_FULL;
                        state_in = S_RESP;
                     end else begin
                        val_in   = req_chan.value;
                        pos_in   = cnt_ff;
                        state_in = S_INS;
                     end
                  end
                  default: begin
                     if (!active_ff) begin
                        active_in   = 1'b1;
                        finished_in = 1'b0;
                        if (cnt_ff == '0) begin
                           finished_in = 1'b1;
                           pend_in     = ST_EXHAUSTED;
                           state_in    = S_RESP;
                        end else begin
                           ram_re   = 1'b1;
                           oi_in    = '0;
                           si_in    = '0;
                           state_in = S_START_D;
                        end
                     end else if (finished_ff) begin
                        pend_in  = ST_EXHAUSTED;
                        state_in = S_RESP;
                     end else begin
                        state_in = S_W_CHK;
                     end
                  end
               endcase
            end
         end
         // shift larger neighbours up, one per read
         S_INS: begin
            if (pos_ff == '0) begin
               ram_we      = 1'b1;
               ram_wa      = '0;
               ram_wd      = val_ff;
               cnt_in      = cnt_ff + ONE;
               active_in   = 1'b0;
               finished_in = 1'b0;
               oi_in = '0; si_in = '0; lo_in = '0; hi_in = '0;
               pend_in     = ST_STORED;
               state_in    = S_RESP;
            end else begin
               ram_re   = 1'b1;
               ram_ra   = AW'(pos_ff - ONE);
               state_in = S_INS_D;
            end
         end
         S_INS_D: begin
            ram_we = 1'b1;
            ram_wa = AW'(pos_ff);
            if (rdata > val_ff) begin
               ram_wd   = rdata;
               pos_in   = pos_ff - ONE;
               state_in = S_INS;
            end else begin
               ram_wd      = val_ff;
               cnt_in      = cnt_ff + ONE;
               active_in   = 1'b0;
               finished_in = 1'b0;
               oi_in = '0; si_in = '0; lo_in = '0; hi_in = '0;
               pend_in     = ST_STORED;
               state_in    = S_RESP;
            end
         end
         S_START_D: begin
            a_in     = rdata;
            b_in     = rdata;
            state_in = S_AP_NEXT;
         end
         // advance the second index, skipping equal neighbours
         S_AP_NEXT: begin
            if (nxt_si < cnt_ff) begin
               ram_re   = 1'b1;
               ram_ra   = AW'(nxt_si);
               state_in = S_AP_D;
            end else begin
               state_in = S_OI_NEXT;
            end
         end
         S_AP_D: begin
            si_in = nxt_si;
            b_in  = rdata;
            if (nxt_si > nxt_oi && rdata == b_ff) begin
               state_in = S_AP_NEXT;
            end else begin
               lo_in    = nxt_si + ONE;
               hi_in    = cnt_ff - ONE;
               ab_in    = 33'(a_ff) + 33'(rdata);
               state_in = S_W_CHK;
            end
         end
         // advance the outer index, skipping equal neighbours
         S_OI_NEXT: begin
            oi_in = nxt_oi;
            if (nxt_oi >= cnt_ff) begin
               finished_in = 1'b1;
               pend_in     = ST_EXHAUSTED;
               state_in    = S_RESP;
            end else begin
               oi_in    = oi_ff;
               ram_re   = 1'b1;
               ram_ra   = AW'(nxt_oi);
               state_in = S_OI_D;
            end
         end
         S_OI_D: begin
            oi_in = nxt_oi;
            a_in  = rdata;
            if (rdata == a_ff) begin
               state_in = S_OI_NEXT;
            end else begin
               si_in    = nxt_oi;
               b_in     = rdata;
               state_in = S_AP_NEXT;
            end
         end
         // two-pointer walk: fetch low, then high, then compare
         S_W_CHK: begin
            if (lo_ff < hi_ff) begin
               ram_re   = 1'b1;
               ram_ra   = AW'(lo_ff);
               state_in = S_W_C;
            end else begin
               state_in = S_AP_NEXT;
            end
         end
         S_W_C: begin
            c_in     = rdata;
            ram_re   = 1'b1;
            ram_ra   = AW'(hi_ff);
            state_in = S_W_D;
         end
         S_W_D: begin
            d_in = rdata;
            if (quad_sum == target_ext) begin
               lo_in    = lo_ff + ONE;
               hi_in    = hi_ff - ONE;
               pend_in  = ST_FOUND;
               state_in = S_SK_L;
            end else if (quad_sum < target_ext) begin
               lo_in    = lo_ff + ONE;
               state_in = S_W_CHK;
            end else begin
               hi_in    = hi_ff - ONE;
               state_in = S_W_CHK;
            end
         end
         // drop duplicates after a hit
         S_SK_L: begin
            if (lo_ff < hi_ff) begin
               ram_re   = 1'b1;
               ram_ra   = AW'(lo_ff);
               state_in = S_SK_LD;
            end else begin
               state_in = S_RESP;
            end
         end
         S_SK_LD: begin
            if (rdata == c_ff) begin
               lo_in    = lo_ff + ONE;
               state_in = S_SK_L;
            end else begin
               state_in = S_SK_H;
            end
         end
         S_SK_H: begin
            if (lo_ff < hi_ff) begin
               ram_re   = 1'b1;
               ram_ra   = AW'(hi_ff);
               state_in = S_SK_HD;
            end else begin
               state_in = S_RESP;
            end
         end
         S_SK_HD: begin
            if (rdata == d_ff) begin
               hi_in    = hi_ff - ONE;
               state_in = S_SK_H;
            end else begin
               state_in = S_RESP;
            end
         end
         // load the response register once it is free
         S_RESP: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = pend_ff;
               if (pend_ff == ST_FOUND) begin
                  rsp_q0_in = a_ff; rsp_q1_in = b_ff;
                  rsp_q2_in = c_ff; rsp_q3_in = d_ff;
               end else begin
                  rsp_q0_in = '0; rsp_q1_in = '0;
                  rsp_q2_in = '0; rsp_q3_in = '0;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         cnt_ff        <= '0;
         oi_ff         <= '0;
         si_ff         <= '0;
         lo_ff         <= '0;
         hi_ff         <= '0;
         active_ff     <= 1'b0;
         finished_ff   <= 1'b0;
         target_sum_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         oi_ff         <= oi_in;
         si_ff         <= si_in;
         lo_ff         <= lo_in;
         hi_ff         <= hi_in;
         active_ff     <= active_in;
         finished_ff   <= finished_in;
         target_sum_ff <= target_sum_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      pos_ff        <= pos_in;
      a_ff          <= a_in;
      b_ff          <= b_in;
      c_ff          <= c_in;
      d_ff          <= d_in;
      ab_ff         <= ab_in;
      val_ff        <= val_in;
      pend_ff       <= pend_in;
      rsp_status_ff <= rsp_status_in;
      rsp_q0_ff     <= rsp_q0_in;
      rsp_q1_ff     <= rsp_q1_in;
      rsp_q2_ff     <= rsp_q2_in;
      rsp_q3_ff     <= rsp_q3_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= MAX_COUNT)
      else $error("element count beyond store depth");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready && req_chan.opcode == OP_CLEAR)
      |=> (cnt_ff == '0 && !active_ff))
      else $error("clear did not empty the store");

   a_walk_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_W_C || state_ff == S_W_D) |-> (hi_ff < cnt_ff && lo_ff < hi_ff))
      else $error("walk pointers out of range");

   a_zero_fill: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != ST_FOUND)
      |-> (rsp_q0_ff == '0 && rsp_q1_ff == '0 && rsp_q2_ff == '0 && rsp_q3_ff == '0))
      else $error("nonzero values without a quadruple");

endmodule
